// File: rtl/atc_pkg.sv
// ---------------------------------------------------------------------------
// atc_pkg
// shared types, constants and tables for the affine transform composer
// ---------------------------------------------------------------------------
package atc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CORDIC_ITERS  = 16;
    localparam int NUM_ELEM      = 12;

    typedef enum logic [2:0] {
        OP_IDENT  = 3'd0,
        OP_SCALE  = 3'd1,
        OP_TRANS  = 3'd2,
        OP_ROT_X  = 3'd3,
        OP_ROT_Y  = 3'd4,
        OP_ROT_Z  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TURN,
        ST_CORDIC,
        ST_MAC,
        ST_OUT
    } state_t;

    function automatic logic signed [31:0] atan_q30(input logic [3:0] i);
        logic signed [31:0] r;
        begin
            case (i)
                4'd0:  r = 32'h3243F6A8;
                4'd1:  r = 32'h1DAC6705;
                4'd2:  r = 32'h0FADBAFC;
                4'd3:  r = 32'h07F56EA6;
                4'd4:  r = 32'h03FEAB76;
                4'd5:  r = 32'h01FFD55B;
                4'd6:  r = 32'h00FFFAAA;
                4'd7:  r = 32'h007FFF55;
                4'd8:  r = 32'h003FFFEA;
                4'd9:  r = 32'h001FFFFD;
                4'd10: r = 32'h000FFFFF;
                4'd11: r = 32'h0007FFFF;
                4'd12: r = 32'h0003FFFF;
                4'd13: r = 32'h0001FFFF;
                4'd14: r = 32'h0000FFFF;
                default: r = 32'h00007FFF;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        begin
            if (v > 48'sh0000_7FFF_FFFF)
                r = 32'sh7FFF_FFFF;
            else if (v < -48'sh0000_8000_0000)
                r = 32'sh8000_0000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

// File: rtl/atc_cordic.sv
// ---------------------------------------------------------------------------
// atc_cordic
// angle to sine and cosine: turn fraction by a 32x64 multiply in two 32x32 steps,
// then one cordic rotation per cycle
// ---------------------------------------------------------------------------
module atc_cordic
    import atc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] angle,
    output logic               done,
    output logic signed [31:0] sin_val,
    output logic signed [31:0] cos_val
);

    typedef enum logic [2:0] {
        CS_IDLE, CS_MUL_HI, CS_MUL_LO, CS_REDUCE, CS_ITER, CS_FIN
    } cstate_t;

    localparam logic [63:0] INV2PI = 64'h28BE60DB9391054A;
    localparam int          SH     = 32 + FRAC_BITS;

    cstate_t            state_reg, state_next;
    logic [31:0]        mag_reg;
    logic               neg_reg;
    logic [63:0]        hp_reg;
    logic [63:0]        lp_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic [3:0]         it_reg;
    logic [1:0]         quad_reg;

    logic [63:0]        plo;
    logic [63:0]        phi;
    logic [127:0]       cat;
    logic [31:0]        turn, t;
    logic signed [31:0] r;
    logic signed [65:0] zp;
    logic signed [33:0] dx, dy, at;
    logic signed [33:0] c_sel, s_sel;

    function automatic logic signed [31:0] to_frac(input logic signed [33:0] v);
        logic signed [33:0] rr;
        logic signed [33:0] one;
        begin
            one = 34'sd1 <<< FRAC_BITS;
            if (FRAC_BITS < 30)
                rr = (v + (34'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
            else
                rr = v;
            if (rr > one)
                rr = one;
            if (rr < -one)
                rr = -one;
            return rr[31:0];
        end
    endfunction

    always_comb
    begin
        plo  = lp_reg + (hp_reg << 32);
        phi  = (hp_reg >> 32) + {63'd0, (plo < lp_reg)};
        cat  = {phi, plo};
        turn = 32'(cat >> SH);
        t    = (neg_reg ? (32'd0 - turn) : turn) + 32'h2000_0000;
        r    = $signed({2'b00, t[29:0]}) - 32'sh2000_0000;
        zp   = $signed(66'(r)) * $signed(66'sh1_921F_B544);
        dx   = y_reg >>> it_reg;
        dy   = x_reg >>> it_reg;
        at   = 34'(atan_q30(it_reg));
        case (quad_reg)
            2'd0:    begin c_sel = x_reg;  s_sel = y_reg;  end
            2'd1:    begin c_sel = -y_reg; s_sel = x_reg;  end
            2'd2:    begin c_sel = -x_reg; s_sel = -y_reg; end
            default: begin c_sel = y_reg;  s_sel = -x_reg; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:   if (start) state_next = CS_MUL_HI;
            CS_MUL_HI: state_next = CS_MUL_LO;
            CS_MUL_LO: state_next = CS_REDUCE;
            CS_REDUCE: state_next = CS_ITER;
            CS_ITER:   if (it_reg == 4'(CORDIC_ITERS - 1)) state_next = CS_FIN;
            CS_FIN:    state_next = CS_IDLE;
            default:   state_next = CS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CS_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            CS_IDLE:
            begin
                neg_reg <= angle[31];
                mag_reg <= angle[31] ? (32'd0 - angle) : angle;
            end
            CS_MUL_HI: hp_reg <= mag_reg * INV2PI[63:32];
            CS_MUL_LO: lp_reg <= mag_reg * INV2PI[31:0];
            CS_REDUCE:
            begin
                quad_reg <= t[31:30];
                z_reg    <= 34'(zp >>> 32);
                x_reg    <= 34'sh0_26DD_3B6A;
                y_reg    <= '0;
                it_reg   <= '0;
            end
            CS_ITER:
            begin
                if (!z_reg[33])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
                it_reg <= it_reg + 4'd1;
            end
            default: ;
        endcase
    end

    // sine and cosine are valid while done is high
    assign done    = (state_reg == CS_FIN);
    assign sin_val = to_frac(s_sel);
    assign cos_val = to_frac(c_sel);

endmodule

// File: rtl/affine_transform_composer_unit.sv
// ---------------------------------------------------------------------------
// affine_transform_composer_unit
// running 4x3 affine transform, composes one operation per input word
// ---------------------------------------------------------------------------
// steps per word: identity and unused codes pass from turn straight to out;
// scale and translate run 36 multiply steps; rotations reduce the angle, run
// 16 cordic iterations, then the 36 multiply steps
// one word at a time: a new word is taken only in idle, once any pending result is taken
// reset: asynchronous, transform returns to identity with zero translation
module affine_transform_composer_unit
    import atc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         operation,
    input  logic signed [31:0] arg_x,
    input  logic signed [31:0] arg_y,
    input  logic signed [31:0] arg_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] row0_col0,
    output logic signed [31:0] row0_col1,
    output logic signed [31:0] row0_col2,
    output logic signed [31:0] row1_col0,
    output logic signed [31:0] row1_col1,
    output logic signed [31:0] row1_col2,
    output logic signed [31:0] row2_col0,
    output logic signed [31:0] row2_col1,
    output logic signed [31:0] row2_col2,
    output logic signed [31:0] shift_x,
    output logic signed [31:0] shift_y,
    output logic signed [31:0] shift_z
);

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    state_t             state_reg, state_next;
    logic signed [31:0] m_reg [NUM_ELEM];
    logic signed [31:0] n_reg [NUM_ELEM];
    logic signed [31:0] op_reg [NUM_ELEM];
    logic [2:0]         opc_reg;
    logic signed [31:0] ax_reg, ay_reg, az_reg;
    logic [3:0]         el_reg;
    logic [1:0]         k_reg;
    logic signed [65:0] acc_reg;
    logic               pend_reg;

    logic               cordic_start, cordic_done;
    logic signed [31:0] sn, cs;
    logic [3:0]         row_base, a_idx, b_idx;
    logic [1:0]         col;
    logic signed [63:0] prod;
    logic signed [65:0] acc_sum, rnd;
    logic signed [47:0] dot_sat_in;
    logic signed [31:0] dot_val;
    logic signed [47:0] tsum;
    logic               is_rot, is_last;
    logic signed [31:0] op_init [NUM_ELEM];

    atc_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (ax_reg),
        .done    (cordic_done),
        .sin_val (sn),
        .cos_val (cs)
    );

    assign is_rot       = (opc_reg == OP_ROT_X) || (opc_reg == OP_ROT_Y) ||
                          (opc_reg == OP_ROT_Z);
    assign cordic_start = (state_reg == ST_TURN) && is_rot;

    always_comb
    begin
        if (el_reg >= 4'd9)
            row_base = 4'd9;
        else if (el_reg >= 4'd6)
            row_base = 4'd6;
        else if (el_reg >= 4'd3)
            row_base = 4'd3;
        else
            row_base = 4'd0;
        col        = 2'(el_reg - row_base);
        a_idx      = row_base + 4'(k_reg);
        b_idx      = 4'(k_reg) * 4'd3 + 4'(col);
        prod       = m_reg[a_idx] * op_reg[b_idx];
        acc_sum    = acc_reg + 66'(prod);
        rnd        = (acc_sum + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (rnd > 66'sh0_7FFF_FFFF)
            dot_val = 32'sh7FFF_FFFF;
        else if (rnd < -66'sh0_8000_0000)
            dot_val = 32'sh8000_0000;
        else
            dot_val = rnd[31:0];
        dot_sat_in = 48'(dot_val);
        tsum       = dot_sat_in + 48'(op_reg[4'(9) + 4'(col)]);
        is_last    = (k_reg == 2'd2) && (el_reg == 4'(NUM_ELEM - 1));
    end

    always_comb
    begin
        for (int i = 0; i < NUM_ELEM; i++)
            op_init[i] = (i == 0 || i == 4 || i == 8) ? ONE : '0;
        if (opc_reg == OP_SCALE)
        begin
            op_init[0] = ax_reg;
            op_init[4] = (ay_reg == '0) ? ax_reg : ay_reg;
            op_init[8] = (az_reg == '0) ? ax_reg : az_reg;
        end
        else if (opc_reg == OP_TRANS)
        begin
            op_init[9]  = ax_reg;
            op_init[10] = ay_reg;
            op_init[11] = az_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid && in_ready)
                    state_next = ST_TURN;
            ST_TURN:
                if (opc_reg == OP_SCALE || opc_reg == OP_TRANS)
                    state_next = ST_MAC;
                else if (is_rot)
                    state_next = ST_CORDIC;
                else
                    state_next = ST_OUT;
            ST_CORDIC:
                if (cordic_done)
                    state_next = ST_MAC;
            ST_MAC:
                if (is_last)
                    state_next = ST_OUT;
            ST_OUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == ST_IDLE) && (!pend_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            for (int i = 0; i < NUM_ELEM; i++)
                m_reg[i] <= (i == 0 || i == 4 || i == 8) ? ONE : '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT)
                pend_reg <= 1'b1;
            else if (out_ready)
                pend_reg <= 1'b0;
            if (state_reg == ST_TURN && opc_reg == OP_IDENT)
                for (int i = 0; i < NUM_ELEM; i++)
                    m_reg[i] <= (i == 0 || i == 4 || i == 8) ? ONE : '0;
            if (state_reg == ST_MAC && is_last)
                for (int i = 0; i < NUM_ELEM - 1; i++)
                    m_reg[i] <= n_reg[i];
            if (state_reg == ST_MAC && is_last)
                m_reg[NUM_ELEM - 1] <= sat32(tsum);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                opc_reg <= operation;
                ax_reg  <= arg_x;
                ay_reg  <= arg_y;
                az_reg  <= arg_z;
            end
            ST_TURN:
            begin
                for (int i = 0; i < NUM_ELEM; i++)
                    op_reg[i] <= op_init[i];
                el_reg  <= '0;
                k_reg   <= '0;
                acc_reg <= '0;
            end
            ST_CORDIC:
                if (cordic_done)
                begin
                    if (opc_reg == OP_ROT_X)
                    begin
                        op_reg[4] <= cs; op_reg[5] <= sn;
                        op_reg[7] <= -sn; op_reg[8] <= cs;
                    end
                    else if (opc_reg == OP_ROT_Y)
                    begin
                        op_reg[0] <= cs; op_reg[2] <= -sn;
                        op_reg[6] <= sn; op_reg[8] <= cs;
                    end
                    else
                    begin
                        op_reg[0] <= cs; op_reg[1] <= sn;
                        op_reg[3] <= -sn; op_reg[4] <= cs;
                    end
                end
            ST_MAC:
            begin
                if (k_reg == 2'd2)
                begin
                    if (el_reg >= 4'd9)
                        n_reg[el_reg] <= sat32(tsum);
                    else
                        n_reg[el_reg] <= dot_val;
                    acc_reg <= '0;
                    k_reg   <= '0;
                    el_reg  <= el_reg + 4'd1;
                end
                else
                begin
                    acc_reg <= acc_sum;
                    k_reg   <= k_reg + 2'd1;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = pend_reg;
    assign row0_col0 = m_reg[0];
    assign row0_col1 = m_reg[1];
    assign row0_col2 = m_reg[2];
    assign row1_col0 = m_reg[3];
    assign row1_col1 = m_reg[4];
    assign row1_col2 = m_reg[5];
    assign row2_col0 = m_reg[6];
    assign row2_col1 = m_reg[7];
    assign row2_col2 = m_reg[8];
    assign shift_x   = m_reg[9];
    assign shift_y   = m_reg[10];
    assign shift_z   = m_reg[11];

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT |=> out_valid)
        else $error("result not presented");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(row0_col0) && $stable(shift_z))
        else $error("result changed while stalled");
`endif

endmodule
